/* hw/rtl/fbm_pkg.sv */
// Package for the S88 feedback bus master: bus constants, phase codes,
// opcodes and the state/result structs shared by the step logic and top.
// No dependencies.
package fbm_pkg;

    localparam int NUM_BUSES   = 4;
    localparam int MAX_SENSORS = 512;

    localparam int CNT_W   = 10;
    localparam int TICK_W  = 16;
    localparam int LANES   = 4;
    localparam int IDX_W   = 9;
    localparam int CFG_W   = 16;
    localparam int CFG_A_W = 3;

    localparam logic [TICK_W-1:0] DEFAULT_PULSE = 16'd50;
    localparam logic [TICK_W-1:0] DEFAULT_READ  = 16'd25;

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    localparam logic [CFG_A_W-1:0] REG_COUNT_0 = 3'd0;
    localparam logic [CFG_A_W-1:0] REG_COUNT_1 = 3'd1;
    localparam logic [CFG_A_W-1:0] REG_COUNT_2 = 3'd2;
    localparam logic [CFG_A_W-1:0] REG_COUNT_3 = 3'd3;
    localparam logic [CFG_A_W-1:0] REG_PULSE   = 3'd4;
    localparam logic [CFG_A_W-1:0] REG_READ    = 3'd5;

    typedef enum logic [3:0] {
        PH_IDLE       = 4'd0,
        PH_LOAD_PRE   = 4'd1,
        PH_CLK_HI     = 4'd2,
        PH_PRE_RESET  = 4'd3,
        PH_RESET_HI   = 4'd4,
        PH_POST_RESET = 4'd5,
        PH_READ_WAIT  = 4'd6,
        PH_SLOT_HI    = 4'd7,
        PH_SLOT_LO    = 4'd8
    } phase_t;

    typedef struct packed {
        phase_t              phase;
        logic [TICK_W-1:0]   tick_count;
        logic [CNT_W-1:0]    bit_index;
        logic                any_more;
    } fbm_state_t;

    typedef struct packed {
        logic             clock_level;
        logic             load_level;
        logic             reset_level;
        logic             busy_res;
        logic             sample_valid;
        logic [IDX_W-1:0] sample_index;
        logic [LANES-1:0] sample_levels;
        logic [LANES-1:0] sample_mask;
        logic             poll_done;
    } fbm_result_t;

endpackage

/* hw/rtl/s88_feedback_bus_master.sv */
// S88 feedback bus master, top level: input register, sequencer state,
// configuration registers and result register. Depends on fbm_pkg, fbm_step.
//
// Each input word is one microsecond tick (opcode 0) or a start command
// (opcode 1) and produces exactly one result word with the clock, load and
// reset line levels after that word, the busy flag, any data sample taken
// and the end-of-poll pulse. A word is held in the input register and is
// then resolved combinationally into the result register, so one word per
// clock is sustained while the result side accepts, and a result is offered
// once its word has passed the input and result registers; the input stalls
// only while both registers hold a word and the result is not taken. The
// rate is set by the sequencer state update. Registers 0..3 hold the sensor
// counts of buses 0..3, 4 the pulse time and 5 the read time in ticks (zero
// acts as one); write them only while no word is in flight. A write during a
// poll applies to the phases and slots that follow it.
module s88_feedback_bus_master (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_opcode,
    input  logic [3:0]                    s_data_levels,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_clock_level,
    output logic                          m_load_level,
    output logic                          m_reset_level,
    output logic                          m_busy_res,
    output logic                          m_sample_valid,
    output logic [8:0]                    m_sample_index,
    output logic [3:0]                    m_sample_levels,
    output logic [3:0]                    m_sample_mask,
    output logic                          m_poll_done,
    input  logic                          cfg_we,
    input  logic [fbm_pkg::CFG_A_W-1:0]   cfg_index,
    input  logic [fbm_pkg::CFG_W-1:0]     cfg_wdata
);

    logic                                          in_valid_reg;
    logic                                          opcode_reg;
    logic [fbm_pkg::LANES-1:0]                     data_reg;
    logic                                          out_valid_reg;
    fbm_pkg::fbm_result_t                          result_reg;
    fbm_pkg::fbm_state_t                           state_reg;
    fbm_pkg::fbm_state_t                           state_next;
    fbm_pkg::fbm_result_t                          result_next;
    logic [fbm_pkg::LANES-1:0][fbm_pkg::CNT_W-1:0] count_reg;
    logic [fbm_pkg::TICK_W-1:0]                    pulse_reg;
    logic [fbm_pkg::TICK_W-1:0]                    read_reg;
    logic                                          advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    fbm_step u_step (
        .cur         (state_reg),
        .opcode      (opcode_reg),
        .data_levels (data_reg),
        .counts      (count_reg),
        .pulse_ticks (pulse_reg),
        .read_ticks  (read_reg),
        .nxt         (state_next),
        .res         (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '{phase: fbm_pkg::PH_IDLE, tick_count: '0,
                               bit_index: '0, any_more: 1'b0};
            count_reg     <= '0;
            pulse_reg     <= fbm_pkg::DEFAULT_PULSE;
            read_reg      <= fbm_pkg::DEFAULT_READ;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we) begin
                unique case (cfg_index)
                    fbm_pkg::REG_COUNT_0: count_reg[0] <= cfg_wdata[fbm_pkg::CNT_W-1:0];
                    fbm_pkg::REG_COUNT_1: count_reg[1] <= cfg_wdata[fbm_pkg::CNT_W-1:0];
                    fbm_pkg::REG_COUNT_2: count_reg[2] <= cfg_wdata[fbm_pkg::CNT_W-1:0];
                    fbm_pkg::REG_COUNT_3: count_reg[3] <= cfg_wdata[fbm_pkg::CNT_W-1:0];
                    fbm_pkg::REG_PULSE:   pulse_reg    <= cfg_wdata;
                    fbm_pkg::REG_READ:    read_reg     <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            opcode_reg <= s_opcode;
            data_reg   <= s_data_levels;
        end
        if (advance) begin
            result_reg <= result_next;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_clock_level   = result_reg.clock_level;
    assign m_load_level    = result_reg.load_level;
    assign m_reset_level   = result_reg.reset_level;
    assign m_busy_res      = result_reg.busy_res;
    assign m_sample_valid  = result_reg.sample_valid;
    assign m_sample_index  = result_reg.sample_index;
    assign m_sample_levels = result_reg.sample_levels;
    assign m_sample_mask   = result_reg.sample_mask;
    assign m_poll_done     = result_reg.poll_done;

`ifndef ASSERT_OFF
    a_idle_index_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.phase == fbm_pkg::PH_IDLE |-> state_reg.bit_index == '0)
        else $error("bit index not cleared while idle");

    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_poll_done |-> !m_busy_res && !m_clock_level)
        else $error("poll done while still busy");

    a_reset_under_load: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_reset_level |-> m_load_level && m_busy_res)
        else $error("reset line high outside load window");

    a_levels_masked: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_sample_levels & ~m_sample_mask) == '0 &&
                    (m_sample_valid == (m_sample_mask != '0)))
        else $error("sample levels outside mask");

    a_advance_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid)
        else $error("result lost after advance");
`endif

endmodule

/* hw/rtl/fbm_step.sv */
// Next-state and result logic for one tick or start word of the bus master.
// Depends on fbm_pkg.
module fbm_step (
    input  fbm_pkg::fbm_state_t                          cur,
    input  logic                                         opcode,
    input  logic [fbm_pkg::LANES-1:0]                    data_levels,
    input  logic [fbm_pkg::LANES-1:0][fbm_pkg::CNT_W-1:0] counts,
    input  logic [fbm_pkg::TICK_W-1:0]                   pulse_ticks,
    input  logic [fbm_pkg::TICK_W-1:0]                   read_ticks,
    output fbm_pkg::fbm_state_t                          nxt,
    output fbm_pkg::fbm_result_t                         res
);

    logic [fbm_pkg::TICK_W-1:0] tick_inc;
    logic [fbm_pkg::TICK_W-1:0] dur_pulse;
    logic [fbm_pkg::TICK_W-1:0] dur_read;
    logic [fbm_pkg::TICK_W-1:0] dur;
    logic [fbm_pkg::LANES-1:0]  mask;

    assign dur_pulse = (pulse_ticks == '0) ? fbm_pkg::TICK_W'(1) : pulse_ticks;
    assign dur_read  = (read_ticks == '0) ? fbm_pkg::TICK_W'(1) : read_ticks;
    assign dur       = (cur.phase == fbm_pkg::PH_READ_WAIT ||
                        cur.phase == fbm_pkg::PH_SLOT_LO) ? dur_read : dur_pulse;
    assign tick_inc  = cur.tick_count + fbm_pkg::TICK_W'(1);

    // buses with a sensor at the current bit position
    always_comb begin
        logic [31:0] c;
        mask = '0;
        for (int b = 0; b < fbm_pkg::LANES; b++) begin
            c = 32'(counts[b]);
            if (c > 32'(fbm_pkg::MAX_SENSORS)) begin
                c = 32'(fbm_pkg::MAX_SENSORS);
            end
            if (b < fbm_pkg::NUM_BUSES && 32'(cur.bit_index) < c) begin
                mask[b] = 1'b1;
            end
        end
    end

    always_comb begin
        nxt = cur;
        res = '0;
        if (opcode == fbm_pkg::OP_START) begin
            if (cur.phase == fbm_pkg::PH_IDLE) begin
                nxt.phase      = fbm_pkg::PH_LOAD_PRE;
                nxt.tick_count = '0;
                nxt.bit_index  = '0;
                nxt.any_more   = 1'b0;
            end
        end else if (cur.phase != fbm_pkg::PH_IDLE) begin
            nxt.tick_count = tick_inc;
            if (tick_inc >= dur) begin
                nxt.tick_count = '0;
                priority if (cur.phase == fbm_pkg::PH_SLOT_HI) begin
                    nxt.phase = fbm_pkg::PH_SLOT_LO;
                end else if (cur.phase == fbm_pkg::PH_SLOT_LO && !cur.any_more) begin
                    nxt.phase     = fbm_pkg::PH_IDLE;
                    nxt.bit_index = '0;
                    res.poll_done = 1'b1;
                end else if (cur.phase == fbm_pkg::PH_READ_WAIT ||
                             cur.phase == fbm_pkg::PH_SLOT_LO) begin
                    nxt.phase = fbm_pkg::PH_SLOT_HI;
                    if (mask != '0) begin
                        res.sample_valid  = 1'b1;
                        res.sample_index  = cur.bit_index[fbm_pkg::IDX_W-1:0];
                        res.sample_levels = data_levels & mask;
                        res.sample_mask   = mask;
                        nxt.bit_index     = cur.bit_index + fbm_pkg::CNT_W'(1);
                        nxt.any_more      = 1'b1;
                    end else begin
                        nxt.any_more = 1'b0;
                    end
                end else begin
                    unique case (cur.phase)
                        fbm_pkg::PH_LOAD_PRE:   nxt.phase = fbm_pkg::PH_CLK_HI;
                        fbm_pkg::PH_CLK_HI:     nxt.phase = fbm_pkg::PH_PRE_RESET;
                        fbm_pkg::PH_PRE_RESET:  nxt.phase = fbm_pkg::PH_RESET_HI;
                        fbm_pkg::PH_RESET_HI:   nxt.phase = fbm_pkg::PH_POST_RESET;
                        fbm_pkg::PH_POST_RESET: nxt.phase = fbm_pkg::PH_READ_WAIT;
                        default:                nxt.phase = fbm_pkg::PH_IDLE;
                    endcase
                end
            end
        end

        res.clock_level = (nxt.phase == fbm_pkg::PH_CLK_HI ||
                           nxt.phase == fbm_pkg::PH_SLOT_HI);
        res.load_level  = (nxt.phase == fbm_pkg::PH_LOAD_PRE ||
                           nxt.phase == fbm_pkg::PH_CLK_HI ||
                           nxt.phase == fbm_pkg::PH_PRE_RESET ||
                           nxt.phase == fbm_pkg::PH_RESET_HI ||
                           nxt.phase == fbm_pkg::PH_POST_RESET);
        res.reset_level = (nxt.phase == fbm_pkg::PH_RESET_HI);
        res.busy_res    = (nxt.phase != fbm_pkg::PH_IDLE);
    end

endmodule
